@@ hw/rtl/tgr_pkg.sv @@
// shared types, constants and helpers of the touch gesture recognizer
package tgr_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DISPLAY_WIDTH  = 280;
    localparam int DISPLAY_HEIGHT = 240;

    localparam int ADDR_BITS    = 4;
    localparam int REG_IDX_BITS = 2;

    localparam logic [15:0] LX_MAX = 16'(DISPLAY_WIDTH - 1);
    localparam logic [15:0] LY_MAX = 16'(DISPLAY_HEIGHT - 1);

    localparam logic [14:0] RST_SWIPE_TH = 15'd30;
    localparam logic [14:0] RST_TAP_TH   = 15'd10;
    localparam logic [15:0] RST_DTAP_WIN = 16'd350;
    localparam logic [15:0] RST_COOLDOWN = 16'd400;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_SWIPE_TH = 2'd0,
        REG_TAP_TH   = 2'd1,
        REG_DTAP_WIN = 2'd2,
        REG_COOLDOWN = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        EK_KEY_DOWN  = 3'd0,
        EK_KEY_UP    = 3'd1,
        EK_KEY_LEFT  = 3'd2,
        EK_KEY_RIGHT = 3'd3,
        EK_ABS_X     = 3'd4,
        EK_ABS_Y     = 3'd5,
        EK_TOUCH     = 3'd6,
        EK_OTHER     = 3'd7
    } t_event_kind;

    localparam logic [2:0] GC_UP    = 3'd0;
    localparam logic [2:0] GC_DOWN  = 3'd1;
    localparam logic [2:0] GC_LEFT  = 3'd2;
    localparam logic [2:0] GC_RIGHT = 3'd3;
    localparam logic [2:0] GC_DTAP  = 3'd4;

    typedef struct packed {
        logic [14:0] swipe_th;
        logic [14:0] tap_th;
        logic [15:0] dtap_win;
        logic [15:0] cooldown;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] event_value;
        logic [31:0] time_ms;
        logic        ui_busy;
    } t_item;

    typedef struct packed {
        logic        gesture_valid;
        logic [2:0]  gesture_code;
        logic        report_valid;
        logic [15:0] report_x;
        logic [15:0] report_y;
        logic        report_touched;
        logic        swiping;
        logic [8:0]  disp_x;
        logic [7:0]  disp_y;
    } t_result;

    // gesture code requested by a gesture key
    function automatic logic [2:0] key_gesture(input logic [1:0] key);
        logic [2:0] code;
        unique case (key)
            2'd0: code = GC_DOWN;
            2'd1: code = GC_UP;
            2'd2: code = GC_LEFT;
            2'd3: code = GC_RIGHT;
        endcase
        return code;
    endfunction

endpackage

@@ hw/rtl/tgr_cfg.sv @@
// apb configuration registers of the touch gesture recognizer
module tgr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output tgr_pkg::t_cfg                 o_cfg
);
    import tgr_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_BITS-1:2]);
    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.swipe_th <= RST_SWIPE_TH;
            r_cfg.tap_th   <= RST_TAP_TH;
            r_cfg.dtap_win <= RST_DTAP_WIN;
            r_cfg.cooldown <= RST_COOLDOWN;
        end else if (wr_en) begin
            unique case (idx)
                REG_SWIPE_TH: r_cfg.swipe_th <= pwdata[14:0];
                REG_TAP_TH:   r_cfg.tap_th   <= pwdata[14:0];
                REG_DTAP_WIN: r_cfg.dtap_win <= pwdata[15:0];
                REG_COOLDOWN: r_cfg.cooldown <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_SWIPE_TH: prdata = {17'd0, r_cfg.swipe_th};
            REG_TAP_TH:   prdata = {17'd0, r_cfg.tap_th};
            REG_DTAP_WIN: prdata = {16'd0, r_cfg.dtap_win};
            REG_COOLDOWN: prdata = {16'd0, r_cfg.cooldown};
        endcase
    end

endmodule

@@ hw/rtl/tgr_core.sv @@
// touch state and gesture decision for one event per cycle while i_step is set
module tgr_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  tgr_pkg::t_item   i_item,
    input  tgr_pkg::t_cfg    i_cfg,
    output tgr_pkg::t_result o_res
);
    import tgr_pkg::*;

    logic [COORD_BITS-1:0] r_coord_x, n_coord_x;
    logic [COORD_BITS-1:0] r_coord_y, n_coord_y;
    logic [COORD_BITS-1:0] r_origin_x, n_origin_x;
    logic [COORD_BITS-1:0] r_origin_y, n_origin_y;
    logic                  r_pressed, n_pressed;
    logic                  r_was_pressed, n_was_pressed;
    logic                  r_in_progress, n_in_progress;
    logic                  r_gesture_done, n_gesture_done;
    logic [31:0]           r_last_gesture, n_last_gesture;
    logic [31:0]           r_last_tap, n_last_tap;

    t_event_kind   kind;
    logic          emit_ok;
    logic [31:0]   since_gesture;
    logic [31:0]   since_tap;
    logic [15:0]   cx16, cy16, ox16, oy16;
    logic [15:0]   dx_u, dy_u, adx_u, ady_u;
    logic signed [16:0] adx, ady, sw, tp;
    logic          dx_pos, dy_pos;
    logic          want;
    logic [2:0]    want_code;
    logic          g_valid;
    logic [2:0]    g_code;
    logic [15:0]   ncx16, ncy16;

    assign kind          = t_event_kind'(i_item.event_kind);
    assign since_gesture = i_item.time_ms - r_last_gesture;
    assign since_tap     = i_item.time_ms - r_last_tap;
    assign emit_ok       = (since_gesture >= {16'd0, i_cfg.cooldown}) && !i_item.ui_busy;

    // drag rotated by 270 degrees
    assign cx16  = 16'(r_coord_x);
    assign cy16  = 16'(r_coord_y);
    assign ox16  = 16'(r_origin_x);
    assign oy16  = 16'(r_origin_y);
    assign dx_u  = cy16 - oy16;
    assign dy_u  = ox16 - cx16;
    assign adx_u = dx_u[15] ? (~dx_u + 16'd1) : dx_u;
    assign ady_u = dy_u[15] ? (~dy_u + 16'd1) : dy_u;
    assign adx   = signed'({adx_u[15], adx_u});
    assign ady   = signed'({ady_u[15], ady_u});
    assign sw    = signed'({2'b00, i_cfg.swipe_th});
    assign tp    = signed'({2'b00, i_cfg.tap_th});
    assign dx_pos = !dx_u[15] && (dx_u != 16'd0);
    assign dy_pos = !dy_u[15] && (dy_u != 16'd0);

    always_comb begin
        n_coord_x      = r_coord_x;
        n_coord_y      = r_coord_y;
        n_origin_x     = r_origin_x;
        n_origin_y     = r_origin_y;
        n_pressed      = r_pressed;
        n_was_pressed  = r_was_pressed;
        n_in_progress  = r_in_progress;
        n_gesture_done = r_gesture_done;
        n_last_gesture = r_last_gesture;
        n_last_tap     = r_last_tap;
        g_valid        = 1'b0;
        g_code         = GC_UP;
        want           = 1'b0;
        want_code      = GC_UP;

        unique case (kind)
            EK_KEY_DOWN, EK_KEY_UP, EK_KEY_LEFT, EK_KEY_RIGHT: begin
                if (i_item.event_value == 16'd1) begin
                    n_gesture_done = 1'b1;
                    if (emit_ok) begin
                        g_valid        = 1'b1;
                        g_code         = key_gesture(i_item.event_kind[1:0]);
                        n_last_gesture = i_item.time_ms;
                    end
                end
            end
            EK_ABS_X: n_coord_x = i_item.event_value[COORD_BITS-1:0];
            EK_ABS_Y: n_coord_y = i_item.event_value[COORD_BITS-1:0];
            EK_TOUCH: begin
                n_pressed = (i_item.event_value != 16'd0);
                if (n_pressed && !r_was_pressed) begin
                    n_origin_x     = r_coord_x;
                    n_origin_y     = r_coord_y;
                    n_in_progress  = 1'b1;
                    n_gesture_done = i_item.ui_busy;
                end else if (!n_pressed) begin
                    if (!r_gesture_done && r_in_progress) begin
                        priority if (ady > adx && ady > sw) begin
                            want      = 1'b1;
                            want_code = dy_pos ? GC_DOWN : GC_UP;
                        end else if (adx > ady && adx > sw) begin
                            want      = 1'b1;
                            want_code = dx_pos ? GC_RIGHT : GC_LEFT;
                        end else if (adx <= tp && ady <= tp) begin
                            if (r_last_tap != 32'd0 && since_tap < {16'd0, i_cfg.dtap_win}) begin
                                n_last_tap = 32'd0;
                                want       = 1'b1;
                                want_code  = GC_DTAP;
                            end else begin
                                n_last_tap = i_item.time_ms;
                            end
                        end else begin
                            want = 1'b0;
                        end
                        if (want && emit_ok) begin
                            g_valid        = 1'b1;
                            g_code         = want_code;
                            n_last_gesture = i_item.time_ms;
                        end
                    end
                    n_in_progress  = 1'b0;
                    n_gesture_done = 1'b0;
                end
                n_was_pressed = n_pressed;
            end
            EK_OTHER: ;
        endcase
    end

    assign ncx16 = 16'(n_coord_x);
    assign ncy16 = 16'(n_coord_y);

    always_comb begin
        o_res.gesture_valid  = g_valid;
        o_res.gesture_code   = g_code;
        o_res.report_valid   = (kind == EK_TOUCH);
        o_res.report_x       = ncx16;
        o_res.report_y       = ncy16;
        o_res.report_touched = n_pressed;
        o_res.swiping        = n_in_progress;
        o_res.disp_x         = (ncy16 > LX_MAX) ? LX_MAX[8:0] : ncy16[8:0];
        o_res.disp_y         = (ncx16 > LY_MAX) ? 8'd0 : 8'(LY_MAX - ncx16);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord_x      <= '0;
            r_coord_y      <= '0;
            r_origin_x     <= '0;
            r_origin_y     <= '0;
            r_pressed      <= 1'b0;
            r_was_pressed  <= 1'b0;
            r_in_progress  <= 1'b0;
            r_gesture_done <= 1'b0;
            r_last_gesture <= 32'd0;
            r_last_tap     <= 32'd0;
        end else if (i_step) begin
            r_coord_x      <= n_coord_x;
            r_coord_y      <= n_coord_y;
            r_origin_x     <= n_origin_x;
            r_origin_y     <= n_origin_y;
            r_pressed      <= n_pressed;
            r_was_pressed  <= n_was_pressed;
            r_in_progress  <= n_in_progress;
            r_gesture_done <= n_gesture_done;
            r_last_gesture <= n_last_gesture;
            r_last_tap     <= n_last_tap;
        end
    end

    // release always ends the touch
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && kind == EK_TOUCH && i_item.event_value == 16'd0
        |=> !r_in_progress && !r_gesture_done && !r_pressed)
        else $error("release left touch state set");

    // emitted gesture restarts the cooldown at its own time
    a_emit_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.gesture_valid |=> r_last_gesture == $past(i_item.time_ms))
        else $error("cooldown not restarted on gesture");

    // a double tap consumes the stored tap
    a_dtap_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.gesture_valid && o_res.gesture_code == GC_DTAP
        |=> r_last_tap == 32'd0)
        else $error("double tap left tap recorded");

    // swiping in the result matches the stored state
    a_swiping_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |=> r_in_progress == $past(o_res.swiping))
        else $error("swiping flag out of step with state");

endmodule

@@ hw/rtl/touch_gesture_recognizer.sv @@
// touch gesture recognizer top level with stream ports and apb configuration
// One touch event is taken per clock cycle in sustained operation while the output is not
// stalled: the event sits in an input register, the touch state and the gesture decision
// are updated combinationally between that register and the result register, and the
// result register is refilled while its previous content is being taken. Every event
// gives exactly one result. Write the configuration registers only while no events are
// in flight.
module touch_gesture_recognizer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // event_value[15:0], time_ms[47:16], ui_busy[48], zero fill
    input  logic [55:0]                   s_axis_tdata,
    // event_kind[2:0]
    input  logic [2:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // report_x[15:0], report_y[31:16], report_touched[32], swiping[33],
    // disp_x[42:34], disp_y[50:43], zero fill
    output logic [55:0]                   m_axis_tdata,
    // gesture_valid[0], gesture_code[3:1], report_valid[4]
    output logic [4:0]                    m_axis_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import tgr_pkg::*;

    t_cfg    cfg;
    t_item   r_in;
    logic    r_in_valid;
    t_result r_out;
    logic    r_out_valid;
    t_result core_res;
    logic    advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in.event_kind  <= s_axis_tuser;
            r_in.event_value <= s_axis_tdata[15:0];
            r_in.time_ms     <= s_axis_tdata[47:16];
            r_in.ui_busy     <= s_axis_tdata[48];
        end
    end

    tgr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tgr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = {r_out.report_valid, r_out.gesture_code, r_out.gesture_valid};
    assign m_axis_tdata  = {5'd0, r_out.disp_y, r_out.disp_x, r_out.swiping,
                            r_out.report_touched, r_out.report_y, r_out.report_x};

endmodule
